/* design/fbd_pkg.sv */
// shared types and constants for the fractional baud divider search
package fbd_pkg;
   localparam int unsigned DL_MAX = 65535;
   localparam int unsigned HIT_SCALE = 1000;

   typedef struct packed {
      logic [2:0] parity_mode;
      logic [3:0] data_bits;
      logic [1:0] stop_bits;
   } fmt_type;

   typedef struct packed {
      logic [5:0] line_control;
      logic       format_ok;
   } lcr_type;

   function automatic lcr_type encode_format(input fmt_type f);
      lcr_type r;
      logic ok;
      ok = ((f.stop_bits == 2'd1) || (f.stop_bits == 2'd2)) &&
           (f.data_bits >= 4'd5) && (f.data_bits <= 4'd8) && (f.parity_mode <= 3'd4);
      r.format_ok = ok;
      r.line_control = '0;
      if (ok) begin
         r.line_control[1:0] = 2'(f.data_bits - 4'd5);
         r.line_control[2] = f.stop_bits[1];
         r.line_control[3] = (f.parity_mode != 3'd0);
         r.line_control[5:4] = (f.parity_mode != 3'd0) ? 2'(f.parity_mode - 3'd1) : 2'd0;
      end
      return r;
   endfunction
endpackage

/* design/fbd_divider.sv */
// restoring bit-serial divider for clock_hz / (16 * baud)
module fbd_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [35:0] divisor,
   output logic        done,
   output logic [31:0] quotient,
   output logic        rem_zero
);
   logic [35:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [36:0] trial;

   assign trial = {rem_ff, quo_ff[31]};

   always_comb begin
      rem_in = rem_ff; quo_in = quo_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         rem_in = '0; quo_in = dividend; cnt_in = 6'd32; busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[30:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            rem_in = 36'(trial - {1'b0, divisor});
            quo_in[0] = 1'b1;
         end else begin
            rem_in = trial[35:0];
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;
   assign rem_zero = (rem_ff == '0);
endmodule

/* design/fbd_mult.sv */
// registered 32x32 multiplier shared by the search sequencer
module fbd_mult (
   input  logic        clock,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [63:0] p
);
   logic [63:0] p_ff;
   always_ff @(posedge clock) begin
      p_ff <= a * b;
   end
   assign p = p_ff;
endmodule

/* design/fractional_baud_divider_search_unit.sv */
// top level: fractional baud divider search with line-control encoding
// request transfer to result valid: a zero baud rate goes straight to the result, an even
// division needs only the 32-step divider, no possible divisor skips the search, else each
// (dl, mul, add) candidate tried takes seven products through one shared 32x32 multiplier
// throughput: one item at a time; req_stall is high from request to result transfer
// reset: sequencer idle, no result pending, clock_hz loaded with 204 MHz
module fractional_baud_divider_search_unit #(
   parameter int unsigned MUL_MAX = 15
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_baud_rate,
   input  logic [2:0]  req_parity_mode,
   input  logic [3:0]  req_data_bits,
   input  logic [1:0]  req_stop_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_divisor_latch,
   output logic [3:0]  rsp_div_add,
   output logic [3:0]  rsp_mul_value,
   output logic [5:0]  rsp_line_control,
   output logic        rsp_format_ok,
   output logic        rsp_rate_ok
);
   // search state machine; per candidate the multiplier forms d = 16*dl*(m+a),
   // baud*d, clk*m, then best_n*d and n*best_d each as a low and a high part
   typedef enum logic [3:0] {
      S_IDLE, S_DIV, S_INIT, S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6,
      S_EVAL, S_NEXT, S_OUT
   } state_type;

   state_type   state_ff;
   logic [31:0] clk_ff;
   logic [31:0] baud_ff;
   fbd_pkg::lcr_type lcr_ff;
   logic        dl0_big_ff;
   logic [15:0] dlmax_ff, dl_ff, best_dl_ff;
   logic [3:0]  mv_ff, dv_ff, best_mv_ff, best_dv_ff;
   logic        have_ff, hit_ff, rate_ok_ff;
   logic [31:0] d_ff, best_d_ff;       // 16*65535*29 < 2^25
   logic [63:0] bd_ff;                 // baud*d <= clk*(m+a) < 2^37
   logic [39:0] n_ff, best_n_ff;       // error numerator < 2^37
   logic [63:0] lhs_ff, rhs_ff;        // cross products < 2^62

   logic        div_start, div_done, div_rz;
   logic [31:0] div_q;
   logic [31:0] ma, mb;
   logic [63:0] mp;

   fbd_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(clk_ff), .divisor({baud_ff, 4'b0000}),
      .done(div_done), .quotient(div_q), .rem_zero(div_rz)
   );

   fbd_mult u_mul (.clock(clock), .a(ma), .b(mb), .p(mp));

   assign div_start = (state_ff == S_IDLE) && req_valid && (req_baud_rate != '0);

   // operand selection for the shared multiplier, product shows up in the next state
   always_comb begin
      ma = '0; mb = '0;
      unique case (state_ff)
         S_M0: begin
            ma = {16'd0, dl_ff};
            mb = {23'd0, ({1'b0, mv_ff} + {1'b0, dv_ff}), 4'd0};
         end
         S_M1: begin ma = baud_ff; mb = mp[31:0]; end          // d straight from the product
         S_M2: begin ma = clk_ff; mb = {28'd0, mv_ff}; end
         S_M3: begin ma = best_n_ff[31:0]; mb = d_ff; end
         S_M4: begin ma = {24'd0, best_n_ff[39:32]}; mb = d_ff; end
         S_M5: begin ma = n_ff[31:0]; mb = best_d_ff; end
         S_M6: begin ma = {24'd0, n_ff[39:32]}; mb = best_d_ff; end
         default: begin ma = '0; mb = '0; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         clk_ff <= 32'd204000000;
         rsp_valid <= 1'b0;
      end else begin
         if (csr_we) clk_ff <= csr_wdata;
         unique case (state_ff)
            S_IDLE: if (req_valid) begin
               baud_ff <= req_baud_rate;
               lcr_ff <= fbd_pkg::encode_format({req_parity_mode, req_data_bits,
                                                 req_stop_bits});
               best_dl_ff <= 16'hFFFF; best_dv_ff <= '0; best_mv_ff <= 4'd1;
               rate_ok_ff <= 1'b0;
               if (req_baud_rate == '0) begin
                  state_ff <= S_OUT; rsp_valid <= 1'b1;
               end else state_ff <= S_DIV;
            end
            S_DIV: if (div_done) begin
               dl0_big_ff <= (div_q > 32'(fbd_pkg::DL_MAX));
               dlmax_ff <= (div_q > 32'(fbd_pkg::DL_MAX)) ? 16'hFFFF : div_q[15:0];
               if (div_rz) begin
                  best_dl_ff <= (div_q > 32'(fbd_pkg::DL_MAX)) ? 16'hFFFF : div_q[15:0];
                  rate_ok_ff <= (div_q != '0) && (div_q <= 32'(fbd_pkg::DL_MAX));
                  state_ff <= S_OUT; rsp_valid <= 1'b1;
               end else begin
                  best_dl_ff <= '0;
                  state_ff <= S_INIT;
               end
            end
            S_INIT: begin
               // a divisor of zero is never tried
               dl_ff <= ((dlmax_ff >> 1) == '0) ? 16'd1 : (dlmax_ff >> 1);
               mv_ff <= 4'd2; dv_ff <= 4'd1;
               have_ff <= 1'b0; hit_ff <= 1'b0;
               best_n_ff <= '0; best_d_ff <= 32'd1;
               if (dlmax_ff == '0) begin
                  state_ff <= S_OUT; rsp_valid <= 1'b1;
               end else state_ff <= S_M0;
            end
            S_M0: state_ff <= S_M1;
            S_M1: begin d_ff <= mp[31:0]; state_ff <= S_M2; end
            S_M2: begin bd_ff <= mp; state_ff <= S_M3; end
            S_M3: begin
               n_ff <= (bd_ff > mp) ? 40'(bd_ff - mp) : 40'(mp - bd_ff);
               state_ff <= S_M4;
            end
            S_M4: begin rhs_ff <= mp; state_ff <= S_M5; end
            S_M5: begin rhs_ff <= rhs_ff + {mp[31:0], 32'd0}; state_ff <= S_M6; end
            S_M6: begin lhs_ff <= mp; state_ff <= S_EVAL; end
            S_EVAL: begin
               // strictly smaller error wins, so the first of equals is kept
               if (!have_ff || ((lhs_ff + {mp[31:0], 32'd0}) < rhs_ff)) begin
                  have_ff <= 1'b1; best_n_ff <= n_ff; best_d_ff <= d_ff;
                  best_dl_ff <= dl_ff; best_dv_ff <= dv_ff; best_mv_ff <= mv_ff;
                  if ((64'(n_ff) * 64'(fbd_pkg::HIT_SCALE)) < bd_ff) hit_ff <= 1'b1;
               end
               state_ff <= S_NEXT;
            end
            S_NEXT: begin
               if ({1'b0, dv_ff} + 5'd1 < {1'b0, mv_ff}) begin
                  dv_ff <= dv_ff + 4'd1; state_ff <= S_M0;
               end else if ({1'b0, mv_ff} < 5'(MUL_MAX)) begin
                  mv_ff <= mv_ff + 4'd1; dv_ff <= 4'd1; state_ff <= S_M0;
               end else if (hit_ff || dl_ff == dlmax_ff) begin
                  rate_ok_ff <= !dl0_big_ff;
                  state_ff <= S_OUT; rsp_valid <= 1'b1;
               end else begin
                  dl_ff <= dl_ff + 16'd1; mv_ff <= 4'd2; dv_ff <= 4'd1;
                  state_ff <= S_M0;
               end
            end
            S_OUT: if (!rsp_stall) begin
               rsp_valid <= 1'b0; state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_divisor_latch = best_dl_ff;
   assign rsp_div_add = best_dv_ff;
   assign rsp_mul_value = best_mv_ff;
   assign rsp_line_control = lcr_ff.line_control;
   assign rsp_format_ok = lcr_ff.format_ok;
   assign rsp_rate_ok = rate_ok_ff;
endmodule

/* bench/tb_fractional_baud_divider_search_unit.sv */
// testbench for the fractional baud divider search unit
module tb_fractional_baud_divider_search_unit;

   // parity mode codes of the request
   localparam logic [2:0] PARITY_NONE  = 3'd0;
   localparam logic [2:0] PARITY_ODD   = 3'd1;
   localparam logic [2:0] PARITY_EVEN  = 3'd2;
   localparam logic [2:0] PARITY_MARK  = 3'd3;
   localparam logic [2:0] PARITY_SPACE = 3'd4;
   localparam logic [2:0] PARITY_RES5  = 3'd5;
   localparam logic [2:0] PARITY_RES6  = 3'd6;
   localparam logic [2:0] PARITY_BAD   = 3'd7;
   localparam int unsigned FRACT_MAX = 15;
   localparam longint unsigned CLOCK_RESET = 64'd204000000;

   typedef struct packed {
      logic [15:0] divisor_latch;
      logic [3:0]  div_add;
      logic [3:0]  mul_value;
      logic [5:0]  line_control;
      logic        format_ok;
      logic        rate_ok;
   } divider_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [31:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_baud_rate = '0;
   logic [2:0]  req_parity_mode = '0;
   logic [3:0]  req_data_bits = '0;
   logic [1:0]  req_stop_bits = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_divisor_latch;
   logic [3:0]  rsp_div_add;
   logic [3:0]  rsp_mul_value;
   logic [5:0]  rsp_line_control;
   logic        rsp_format_ok;
   logic        rsp_rate_ok;

   // bench copy of the clock_hz register
   longint unsigned      clock_hz_shadow = CLOCK_RESET;
   divider_result_type   expected_divisors[$];
   int                   sender_idle_pct = 0;
   int                   receiver_stall_pct = 0;
   int                   mismatch_count = 0;

   fractional_baud_divider_search_unit u_dut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall), .req_baud_rate(req_baud_rate),
      .req_parity_mode(req_parity_mode), .req_data_bits(req_data_bits),
      .req_stop_bits(req_stop_bits), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_divisor_latch(rsp_divisor_latch), .rsp_div_add(rsp_div_add),
      .rsp_mul_value(rsp_mul_value), .rsp_line_control(rsp_line_control),
      .rsp_format_ok(rsp_format_ok), .rsp_rate_ok(rsp_rate_ok)
   );

   always #5 clock = ~clock;

   // divisor search and frame encoding, all products kept modulo 2^64
   function automatic divider_result_type search_divider(input logic [31:0] baud_in,
         input logic [2:0] parity, input logic [3:0] dbits, input logic [1:0] sbits);
      divider_result_type r;
      longint unsigned baud, clk, den, dl0, rem, dlmax, dlv, mv, dv, d, n, a, b;
      longint unsigned best_n, best_d, dl, dav, mul;
      bit have, hit, rate_ok, fmt_ok;
      baud = 64'(baud_in);
      clk = clock_hz_shadow;
      dl = 0;
      dav = 0;
      mul = 1;
      rate_ok = 0;
      if (baud == 0) begin
         dl = 65535;
      end else begin
         den = 16 * baud;
         dl0 = clk / den;
         rem = clk % den;
         dlmax = (dl0 > 65535) ? 65535 : dl0;
         if (rem == 0) begin
            dl = dlmax;
            rate_ok = (dl0 != 0) && (dl0 <= 65535);
         end else begin
            have = 0;
            hit = 0;
            best_n = 0;
            best_d = 1;
            for (dlv = dlmax / 2; dlv <= dlmax && !hit; dlv++) begin
               if (dlv == 0) continue;
               for (mv = 1; mv <= FRACT_MAX; mv++) begin
                  for (dv = 1; dv < mv; dv++) begin
                     // relative error is n / (baud * d)
                     d = 16 * dlv * (mv + dv);
                     a = baud * d;
                     b = clk * mv;
                     n = (a > b) ? a - b : b - a;
                     if (!have || n * best_d < best_n * d) begin
                        have = 1;
                        best_n = n;
                        best_d = d;
                        dl = dlv;
                        dav = dv;
                        mul = mv;
                        if (1000 * n < baud * d) hit = 1;
                     end
                  end
               end
            end
            rate_ok = have && (dl0 <= 65535);
         end
      end
      fmt_ok = (sbits == 2'd1 || sbits == 2'd2) && dbits >= 4'd5 && dbits <= 4'd8 &&
               parity <= PARITY_SPACE;
      r.line_control = '0;
      if (fmt_ok) begin
         r.line_control[1:0] = dbits[1:0] - 2'd1;
         r.line_control[2] = (sbits == 2'd2);
         r.line_control[3] = (parity != PARITY_NONE);
         r.line_control[5:4] = (parity != PARITY_NONE) ? 2'(parity - 3'd1) : 2'd0;
      end
      r.divisor_latch = dl[15:0];
      r.div_add = dav[3:0];
      r.mul_value = mul[3:0];
      r.format_ok = fmt_ok;
      r.rate_ok = rate_ok;
      return r;
   endfunction

   // one request transfer; valid stays up into the next request unless idling
   task automatic send_request(input logic [31:0] baud, input logic [2:0] parity,
         input logic [3:0] dbits, input logic [1:0] sbits);
      req_valid <= 1'b1;
      req_baud_rate <= baud;
      req_parity_mode <= parity;
      req_data_bits <= dbits;
      req_stop_bits <= sbits;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_divisors.push_back(search_divider(baud, parity, dbits, sbits));
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_divisors.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_clock_hz(input logic [31:0] value);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      clock_hz_shadow = 64'(value);
      @(posedge clock);
   endtask

   // baud rates that keep the search short: small divisors unless the clock divides evenly
   function automatic logic [31:0] pick_baud();
      longint unsigned clk, baud, den;
      int k;
      clk = clock_hz_shadow;
      forever begin
         k = $urandom_range(99);
         if (k < 10) baud = 64'($urandom);
         else if (k < 15) baud = clk / 16 / $urandom_range(1, 3) * $urandom_range(1, 2);
         else begin
            baud = clk / (16 * $urandom_range(1, 14));
            baud = baud + $urandom_range(0, 40) - 20;
         end
         baud = baud & 64'hFFFF_FFFF;
         if (baud == 0) continue;
         den = 16 * baud;
         if (clk % den == 0 || clk / den <= 30) return baud[31:0];
      end
   endfunction

   // response side: random stall, compare each transfer with the oldest expectation
   always @(posedge clock) begin
      divider_result_type exp_r, got;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_divisor_latch, rsp_div_add, rsp_mul_value, rsp_line_control,
                   rsp_format_ok, rsp_rate_ok};
            if (expected_divisors.size() == 0) begin
               $display("%0t: unexpected result transfer %p", $time, got);
               mismatch_count++;
            end else begin
               exp_r = expected_divisors.pop_front();
               if (got.divisor_latch !== exp_r.divisor_latch) begin
                  $display("%0t: divisor_latch expected %0d got %0d", $time,
                           exp_r.divisor_latch, got.divisor_latch);
                  mismatch_count++;
               end
               if (got.div_add !== exp_r.div_add) begin
                  $display("%0t: div_add expected %0d got %0d", $time,
                           exp_r.div_add, got.div_add);
                  mismatch_count++;
               end
               if (got.mul_value !== exp_r.mul_value) begin
                  $display("%0t: mul_value expected %0d got %0d", $time,
                           exp_r.mul_value, got.mul_value);
                  mismatch_count++;
               end
               if (got.line_control !== exp_r.line_control) begin
                  $display("%0t: line_control expected %h got %h", $time,
                           exp_r.line_control, got.line_control);
                  mismatch_count++;
               end
               if (got.format_ok !== exp_r.format_ok) begin
                  $display("%0t: format_ok expected %b got %b", $time,
                           exp_r.format_ok, got.format_ok);
                  mismatch_count++;
               end
               if (got.rate_ok !== exp_r.rate_ok) begin
                  $display("%0t: rate_ok expected %b got %b", $time,
                           exp_r.rate_ok, got.rate_ok);
                  mismatch_count++;
               end
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   // edge rates, saturation, missing divisor and every frame format field
   task automatic test_directed();
      send_request(32'd0, PARITY_NONE, 4'd8, 2'd1);
      send_request(32'hFFFF_FFFF, PARITY_ODD, 4'd5, 2'd2);
      send_request(32'd12750000, PARITY_EVEN, 4'd7, 2'd1);
      send_request(32'd1, PARITY_MARK, 4'd6, 2'd1);
      send_request(32'd3, PARITY_SPACE, 4'd8, 2'd2);
      send_request(32'd9600, PARITY_NONE, 4'd8, 2'd1);
      send_request(32'd115200, PARITY_EVEN, 4'd8, 2'd2);
      send_request(32'd6375000, PARITY_BAD, 4'd8, 2'd1);
      send_request(32'd12750000, PARITY_RES5, 4'd5, 2'd1);
      send_request(32'd12750000, PARITY_RES6, 4'd5, 2'd1);
      send_request(32'd12750000, PARITY_NONE, 4'd0, 2'd1);
      send_request(32'd12750000, PARITY_NONE, 4'd4, 2'd1);
      send_request(32'd12750000, PARITY_NONE, 4'd9, 2'd1);
      send_request(32'd12750000, PARITY_NONE, 4'd15, 2'd2);
      send_request(32'd12750000, PARITY_ODD, 4'd6, 2'd0);
      send_request(32'd12750000, PARITY_ODD, 4'd6, 2'd3);
      send_request(32'd13000000, PARITY_MARK, 4'd7, 2'd2);
      send_request(32'd5000000, PARITY_SPACE, 4'd5, 2'd1);
      wait_drained();
   endtask

   task automatic test_random(input int count);
      logic [2:0] parity;
      logic [3:0] dbits;
      logic [1:0] sbits;
      repeat (count) begin
         // mostly valid frames, some garbage format fields
         if ($urandom_range(3) == 0) begin
            parity = 3'($urandom);
            dbits = 4'($urandom);
            sbits = 2'($urandom);
         end else begin
            parity = 3'($urandom_range(0, 4));
            dbits = 4'($urandom_range(5, 8));
            sbits = 2'($urandom_range(1, 2));
         end
         send_request(pick_baud(), parity, dbits, sbits);
      end
      wait_drained();
   endtask

   // several clock settings, each run under all idling mixes
   task automatic test_clock_settings();
      logic [31:0] clocks[5];
      clocks = '{32'd1, 32'hFFFF_FFFF, 32'd14745600, 32'd204000000, 32'h0};
      clocks[4] = $urandom;
      foreach (clocks[i]) begin
         write_clock_hz(clocks[i]);
         sender_idle_pct = 0;   receiver_stall_pct = 0;  test_random(6);
         sender_idle_pct = 84;  receiver_stall_pct = 0;  test_random(6);
         sender_idle_pct = 0;   receiver_stall_pct = 84; test_random(6);
         sender_idle_pct = 18;  receiver_stall_pct = 18; test_random(6);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_clock_settings();
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // guard against a hung handshake
   initial begin
      #400000000;
      $display("Simulation FAILED");
      $finish;
   end
endmodule

/* sim.f */
design/fbd_pkg.sv
design/fbd_divider.sv
design/fbd_mult.sv
design/fractional_baud_divider_search_unit.sv
bench/tb_fractional_baud_divider_search_unit.sv
